>>> rtl/abpf_pkg.sv
package abpf_pkg;

   localparam int MAX_CHANNELS_DEF = 8;
   localparam int MAX_SAMPLES_DEF  = 255;
   localparam int QUEUE_DEPTH      = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [3:0]  CHANNELS_RESET = 4'd5;
   localparam logic [7:0]  SAMPLES_RESET  = 8'd80;
   localparam logic        REVERSE_RESET  = 1'b1;
   localparam logic [15:0] SYNC_RESET     = 16'hAABB;

   typedef enum logic [1:0] {
      REG_CHANNELS = 2'd0,
      REG_SAMPLES  = 2'd1,
      REG_REVERSE  = 2'd2,
      REG_SYNC     = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_CRC    = 2'd2
   } byte_kind_type;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_SYNC_HI,
      STEP_SYNC_LO,
      STEP_PACKET,
      STEP_DATA_LO,
      STEP_DATA_HI,
      STEP_CRC_LO,
      STEP_CRC_HI
   } step_type;

   typedef struct packed {
      logic [3:0]  channels;
      logic [7:0]  samples;
      logic        reverse;
      logic [15:0] sync;
   } cfg_type;

   // One classified reading, as handed from the front to the back.
   typedef struct packed {
      logic        header;
      logic        tail;
      logic [15:0] sync;
      logic [7:0]  packet;
      logic [7:0]  lo;
      logic [7:0]  hi;
   } cmd_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] flip8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

>>> rtl/abpf_front.sv
module abpf_front #(
   parameter int MAX_CHANNELS = abpf_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_SAMPLES  = abpf_pkg::MAX_SAMPLES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  abpf_pkg::cfg_type cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        low_byte,
   input  logic [7:0]        high_byte_raw,
   input  logic              q_full,
   output logic              q_push,
   output abpf_pkg::cmd_type q_cmd
);
   import abpf_pkg::*;

   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CMP_W = 5;

   logic [CH_W-1:0]  ch_idx_ff, ch_idx_in;
   logic [7:0]       smp_idx_ff, smp_idx_in;
   logic [7:0]       packet_ff, packet_in;
   logic [CMP_W-1:0] nch, ch_cfg, ch_max, ch_plus;
   logic [8:0]       nsm, smp_cfg, smp_max, smp_plus;
   logic             set_end, packet_end;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      ch_cfg = {1'b0, cfg.channels};
      ch_max = CMP_W'(MAX_CHANNELS);
      if (ch_cfg == '0) begin
         nch = CMP_W'(1);
      end else if (ch_cfg > ch_max) begin
         nch = ch_max;
      end else begin
         nch = ch_cfg;
      end
      smp_cfg = {1'b0, cfg.samples};
      smp_max = 9'(MAX_SAMPLES);
      if (smp_cfg == '0) begin
         nsm = 9'd1;
      end else if (smp_cfg > smp_max) begin
         nsm = smp_max;
      end else begin
         nsm = smp_cfg;
      end
   end

   // An index at or past a lowered count closes the set or packet right away.
   assign ch_plus    = CMP_W'(ch_idx_ff) + CMP_W'(1);
   assign smp_plus   = {1'b0, smp_idx_ff} + 9'd1;
   assign set_end    = ch_plus >= nch;
   assign packet_end = set_end && (smp_plus >= nsm);

   always_comb begin
      q_cmd.header = (ch_idx_ff == '0) && (smp_idx_ff == '0);
      q_cmd.tail   = packet_end;
      q_cmd.sync   = cfg.sync;
      q_cmd.packet = packet_ff;
      q_cmd.lo     = low_byte;
      q_cmd.hi     = cfg.reverse ? flip8(high_byte_raw) : high_byte_raw;
   end

   always_comb begin
      ch_idx_in  = ch_idx_ff;
      smp_idx_in = smp_idx_ff;
      packet_in  = packet_ff;
      if (q_push) begin
         if (!set_end) begin
            ch_idx_in = ch_plus[CH_W-1:0];
         end else begin
            ch_idx_in = '0;
            if (packet_end) begin
               smp_idx_in = '0;
               packet_in  = packet_ff + 8'd1;
            end else begin
               smp_idx_in = smp_plus[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_idx_ff  <= '0;
         smp_idx_ff <= '0;
         packet_ff  <= '0;
      end else begin
         ch_idx_ff  <= ch_idx_in;
         smp_idx_ff <= smp_idx_in;
         packet_ff  <= packet_in;
      end
   end

endmodule

>>> rtl/abpf_queue.sv
module abpf_queue #(
   parameter int DEPTH = abpf_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  abpf_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output abpf_pkg::cmd_type pop_cmd,
   output logic              empty
);
   import abpf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/abpf_back.sv
module abpf_back (
   input  logic              clock,
   input  logic              reset,
   input  abpf_pkg::cmd_type q_cmd,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,  // out_byte
   output logic [2:0]        rsp_tuser,  // byte_kind[1:0], last_of_run[2]
   output logic              rsp_tlast   // end_of_packet
);
   import abpf_pkg::*;

   step_type      step_ff, step_in;
   cmd_type       cmd_ff;
   logic [15:0]   crc_ff, crc_in;
   logic          out_valid_ff;
   logic [7:0]    out_byte_ff;
   byte_kind_type out_kind_ff;
   logic          out_eop_ff, out_last_ff;

   logic          emits, slot_free, adv, finishing, load;
   logic [7:0]    byte_in;
   byte_kind_type kind_in;
   logic          eop_in, last_in;
   logic [15:0]   crc_zero, crc_final;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign emits     = (step_ff != STEP_IDLE);
   assign adv       = emits && slot_free;
   assign finishing = adv && (((step_ff == STEP_DATA_HI) && !cmd_ff.tail)
                              || (step_ff == STEP_CRC_HI));
   assign load      = !q_empty && ((step_ff == STEP_IDLE) || finishing);
   assign q_pop     = load;
   // The checksum slot counts as two zero bytes, folded in together with the low CRC byte.
   assign crc_zero  = crc_byte(crc_ff, 8'h00);
   assign crc_final = crc_byte(crc_zero, 8'h00);

   // Next state.
   always_comb begin
      step_in = step_ff;
      if (load) begin
         step_in = q_cmd.header ? STEP_SYNC_HI : STEP_DATA_LO;
      end else if (adv) begin
         unique case (step_ff)
            STEP_SYNC_HI: step_in = STEP_SYNC_LO;
            STEP_SYNC_LO: step_in = STEP_PACKET;
            STEP_PACKET:  step_in = STEP_DATA_LO;
            STEP_DATA_LO: step_in = STEP_DATA_HI;
            STEP_DATA_HI: step_in = cmd_ff.tail ? STEP_CRC_LO : STEP_IDLE;
            STEP_CRC_LO:  step_in = STEP_CRC_HI;
            STEP_CRC_HI:  step_in = STEP_IDLE;
            default:      step_in = STEP_IDLE;
         endcase
      end
   end

   // Byte and CRC of the current step.
   always_comb begin
      byte_in = 8'h00;
      kind_in = KIND_HEADER;
      eop_in  = 1'b0;
      last_in = 1'b0;
      crc_in  = crc_ff;
      unique case (step_ff)
         STEP_SYNC_HI: begin
            byte_in = cmd_ff.sync[15:8];
            crc_in  = crc_byte(crc_ff, byte_in);
         end
         STEP_SYNC_LO: begin
            byte_in = cmd_ff.sync[7:0];
            crc_in  = crc_byte(crc_ff, byte_in);
         end
         STEP_PACKET: begin
            byte_in = cmd_ff.packet;
            crc_in  = crc_byte(crc_ff, byte_in);
         end
         STEP_DATA_LO: begin
            byte_in = cmd_ff.lo;
            kind_in = KIND_DATA;
            crc_in  = crc_byte(crc_ff, byte_in);
         end
         STEP_DATA_HI: begin
            byte_in = cmd_ff.hi;
            kind_in = KIND_DATA;
            last_in = !cmd_ff.tail;
            crc_in  = crc_byte(crc_ff, byte_in);
         end
         STEP_CRC_LO: begin
            byte_in = crc_final[7:0];
            kind_in = KIND_CRC;
            crc_in  = crc_final;
         end
         STEP_CRC_HI: begin
            byte_in = crc_ff[15:8];
            kind_in = KIND_CRC;
            eop_in  = 1'b1;
            last_in = 1'b1;
            crc_in  = CRC_INIT;
         end
         default: begin
            crc_in = crc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (adv) begin
            crc_ff <= crc_in;
         end
         if (adv && emits) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= q_cmd;
      end
      if (adv && emits) begin
         out_byte_ff <= byte_in;
         out_kind_ff <= kind_in;
         out_eop_ff  <= eop_in;
         out_last_ff <= last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_last_ff, out_kind_ff};
   assign rsp_tlast  = out_eop_ff;

endmodule

>>> rtl/adc_batch_packet_framer_crc16.sv
// Channel   Direction  Transfer content
// req_*     in         one ADC reading: tdata = low_byte[7:0], high_byte_raw[15:8]
// rsp_*     out        one packet byte: tdata = out_byte, tuser = byte_kind, last_of_run
// csr_*     in         register writes and reads, byte address 4 * register index
//
// The back end sends one byte per cycle while rsp_tready is high: a reading gives 2
// bytes, 5 when it opens a packet, and 2 more CRC bytes when it closes one: 2 to 7 bytes.
// The front end classifies one reading per cycle into a 2-entry queue until it fills.
// Reset is synchronous and restores the register defaults, the counters and the CRC.
// A stall on rsp_* holds the byte register; readings are taken until the queue fills.
module adc_batch_packet_framer_crc16 #(
   parameter int MAX_CHANNELS = abpf_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_SAMPLES  = abpf_pkg::MAX_SAMPLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // low_byte, high_byte_raw
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // out_byte
   output logic [2:0]                      rsp_tuser,   // byte_kind[1:0], last_of_run[2]
   output logic                            rsp_tlast,   // end_of_packet
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [abpf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [abpf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [abpf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import abpf_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   csr_reg_type reg_sel;
   logic        csr_write;
   logic        q_full, q_empty, q_push, q_pop;
   cmd_type     push_cmd, pop_cmd;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_reg_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_CHANNELS: cfg_in.channels = csr_pwdata[3:0];
            REG_SAMPLES:  cfg_in.samples  = csr_pwdata[7:0];
            REG_REVERSE:  cfg_in.reverse  = csr_pwdata[0];
            REG_SYNC:     cfg_in.sync     = csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CHANNELS: csr_prdata = CSR_DATA_W'(cfg_ff.channels);
         REG_SAMPLES:  csr_prdata = CSR_DATA_W'(cfg_ff.samples);
         REG_REVERSE:  csr_prdata = CSR_DATA_W'(cfg_ff.reverse);
         REG_SYNC:     csr_prdata = CSR_DATA_W'(cfg_ff.sync);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channels <= CHANNELS_RESET;
         cfg_ff.samples  <= SAMPLES_RESET;
         cfg_ff.reverse  <= REVERSE_RESET;
         cfg_ff.sync     <= SYNC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   abpf_front #(
      .MAX_CHANNELS(MAX_CHANNELS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .low_byte     (req_tdata[7:0]),
      .high_byte_raw(req_tdata[15:8]),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (push_cmd)
   );

   abpf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(push_cmd),
      .full    (q_full),
      .pop     (q_pop),
      .pop_cmd (pop_cmd),
      .empty   (q_empty)
   );

   abpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_cmd     (pop_cmd),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

>>> rtl/abpf_checker.sv
module abpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);
   import abpf_pkg::*;

   // A byte waiting on a stalled sink stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result byte changed while stalled");

   // The packet ends only on a CRC byte, which also closes the reading's bytes.
   a_eop_is_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1:0] == KIND_CRC && rsp_tuser[2])
      else $error("end of packet on a byte that is not the final CRC byte");

   // A header byte is never the last byte caused by a reading.
   a_header_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_HEADER |-> !rsp_tuser[2] && !rsp_tlast)
      else $error("header byte marked as last");

   // A CRC low byte is always followed by the CRC high byte that ends the packet.
   a_crc_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[1:0] == KIND_CRC && !rsp_tlast
      |=> rsp_tvalid && rsp_tuser[1:0] == KIND_CRC && rsp_tlast)
      else $error("CRC low byte not followed by CRC high byte");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind adc_batch_packet_framer_crc16 abpf_checker u_abpf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/testbench.sv
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import abpf_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 200;
   localparam int DIRECTED_COUNT = 18;

   typedef struct {
      logic [7:0]    out_byte;
      byte_kind_type kind;
      logic          eop;
      logic          last;
   } packet_byte_type;

   // known holds the first n_known bytes of the run, first byte in the top bits.
   typedef struct packed {
      logic [2:0]  phase;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [2:0]  n_known;
      logic [39:0] known;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{3'd0, 8'h00, 8'h01, 3'd5, 40'hAABB000080},
      '{3'd0, 8'hFF, 8'hFF, 3'd2, 40'hFFFF000000},
      '{3'd0, 8'h80, 8'h80, 3'd2, 40'h8001000000},
      '{3'd0, 8'h01, 8'h0F, 3'd2, 40'h01F0000000},
      '{3'd0, 8'h55, 8'hAA, 3'd2, 40'h5555000000},
      '{3'd1, 8'h12, 8'h34, 3'd2, 40'h1234000000},
      '{3'd1, 8'h00, 8'hFF, 3'd5, 40'h12340100FF},
      '{3'd1, 8'hFF, 8'h00, 3'd5, 40'h123402FF00},
      '{3'd1, 8'hA5, 8'h5A, 3'd5, 40'h123403A55A},
      '{3'd2, 8'h3C, 8'hC3, 3'd5, 40'h0000043CC3},
      '{3'd2, 8'hF0, 8'h0F, 3'd5, 40'h000005F0F0},
      '{3'd3, 8'h01, 8'h02, 3'd5, 40'hFFFF060140},
      '{3'd3, 8'h7E, 8'hE7, 3'd2, 40'h7EE7000000},
      '{3'd3, 8'h33, 8'hCC, 3'd0, 40'h0},
      '{3'd3, 8'h00, 8'h00, 3'd0, 40'h0},
      '{3'd3, 8'hFF, 8'hFF, 3'd0, 40'h0},
      '{3'd4, 8'h81, 8'h18, 3'd2, 40'h8118000000},
      '{3'd4, 8'h44, 8'h22, 3'd5, 40'hFFFF074444}
   };

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata   = '0;   // low_byte[7:0], high_byte_raw[15:8]
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [7:0]            rsp_tdata;          // out_byte[7:0]
   logic [2:0]            rsp_tuser;          // byte_kind[1:0], last_of_run[2]
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow of the block: register settings and framing state.
   logic [3:0]   cfg_channels;
   logic [7:0]   cfg_samples;
   logic         cfg_reverse;
   logic [15:0]  cfg_sync;
   logic [2:0]   channel_pos;
   logic [7:0]   sample_pos;
   logic [7:0]   packet_no;
   logic [15:0]  packet_crc;

   packet_byte_type pending_bytes [$];
   int           run_length;
   int           failures     = 0;
   int           idle_pct     = 20;
   logic         hold_request = 1'b0;
   int           hold_left    = 0;
   bit           hold_taken   = 0;
   int           quiet_cycles = 0;

   adc_batch_packet_framer_crc16 i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] r;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ data[i]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] mirror_byte(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[i];
      end
      return r;
   endfunction

   function automatic void emit_byte(input logic [7:0] b, input byte_kind_type kind,
                                     input logic eop, input logic last);
      packet_byte_type e;
      e.out_byte = b;
      e.kind     = kind;
      e.eop      = eop;
      e.last     = last;
      pending_bytes.push_back(e);
      if (kind != KIND_CRC) begin
         packet_crc = crc16_next(packet_crc, b);
      end
      run_length++;
   endfunction

   // Works out the bytes that one accepted reading produces and advances the framing state.
   function automatic void frame_reading(input logic [7:0] lo, input logic [7:0] hi_raw);
      int         nch;
      int         nsm;
      bit         ends_set;
      bit         ends_packet;
      logic [7:0] hi;
      logic [15:0] c;
      nch = (cfg_channels == 0) ? 1 : int'(cfg_channels);
      if (nch > MAX_CHANNELS_DEF) begin
         nch = MAX_CHANNELS_DEF;
      end
      nsm = (cfg_samples == 0) ? 1 : int'(cfg_samples);
      if (nsm > MAX_SAMPLES_DEF) begin
         nsm = MAX_SAMPLES_DEF;
      end
      ends_set    = (int'(channel_pos) + 1 >= nch);
      ends_packet = ends_set && (int'(sample_pos) + 1 >= nsm);
      run_length  = 0;
      if (channel_pos == 0 && sample_pos == 0) begin
         emit_byte(cfg_sync[15:8], KIND_HEADER, 1'b0, 1'b0);
         emit_byte(cfg_sync[7:0], KIND_HEADER, 1'b0, 1'b0);
         emit_byte(packet_no, KIND_HEADER, 1'b0, 1'b0);
      end
      hi = cfg_reverse ? mirror_byte(hi_raw) : hi_raw;
      emit_byte(lo, KIND_DATA, 1'b0, 1'b0);
      emit_byte(hi, KIND_DATA, 1'b0, !ends_packet);
      if (ends_set) begin
         channel_pos = '0;
         if (ends_packet) begin
            // The checksum slot is counted as two zero bytes.
            c = crc16_next(crc16_next(packet_crc, 8'h00), 8'h00);
            emit_byte(c[7:0], KIND_CRC, 1'b0, 1'b0);
            emit_byte(c[15:8], KIND_CRC, 1'b1, 1'b1);
            packet_crc = CRC_INIT;
            sample_pos = '0;
            packet_no  = packet_no + 8'd1;
         end else begin
            sample_pos = sample_pos + 8'd1;
         end
      end else begin
         channel_pos = channel_pos + 3'd1;
      end
   endfunction

   task automatic send_reading(input logic [7:0] lo, input logic [7:0] hi);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {hi, lo};
      do begin
         @(posedge clock);
      end while (!req_tready);
      frame_reading(lo, hi);
   endtask

   task automatic check_register(input csr_reg_type r, input logic [31:0] want);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {r, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      got = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", r.name(), want, got);
         failures++;
      end
   endtask

   // Bits above the register's width carry random values and must be dropped by the block.
   task automatic program_register(input csr_reg_type r, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] wdata;
      case (r)
         REG_CHANNELS: mask = 32'h0000_000F;
         REG_SAMPLES:  mask = 32'h0000_00FF;
         REG_REVERSE:  mask = 32'h0000_0001;
         default:      mask = 32'h0000_FFFF;
      endcase
      wdata = (value & mask) | ($urandom() & ~mask);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (r)
         REG_CHANNELS: cfg_channels = wdata[3:0];
         REG_SAMPLES:  cfg_samples  = wdata[7:0];
         REG_REVERSE:  cfg_reverse  = wdata[0];
         default:      cfg_sync     = wdata[15:0];
      endcase
      check_register(r, wdata & mask);
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
   endtask

   always @(posedge clock) begin : byte_check
      packet_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            $error("out_byte: no byte expected, actual %02h", rsp_tdata);
            failures++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_tdata);
               failures++;
            end
            if (rsp_tuser[1:0] !== want.kind) begin
               $error("byte_kind: expected %0d, actual %0d", want.kind, rsp_tuser[1:0]);
               failures++;
            end
            if (rsp_tlast !== want.eop) begin
               $error("end_of_packet: expected %0d, actual %0d", want.eop, rsp_tlast);
               failures++;
            end
            if (rsp_tuser[2] !== want.last) begin
               $error("last_of_run: expected %0d, actual %0d", want.last, rsp_tuser[2]);
               failures++;
            end
         end
      end
      // A single long hold-off lets the internal queue fill and back up the input.
      if (hold_request && !hold_taken) begin
         hold_taken = 1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int         base;
      int         count;
      logic [2:0] phase_now;
      logic [39:0] known;
      cfg_channels = CHANNELS_RESET;
      cfg_samples  = SAMPLES_RESET;
      cfg_reverse  = REVERSE_RESET;
      cfg_sync     = SYNC_RESET;
      channel_pos  = '0;
      sample_pos   = '0;
      packet_no    = '0;
      packet_crc   = CRC_INIT;
      phase_now    = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_register(REG_CHANNELS, 32'(CHANNELS_RESET));
      check_register(REG_SAMPLES, 32'(SAMPLES_RESET));
      check_register(REG_REVERSE, 32'(REVERSE_RESET));
      check_register(REG_SYNC, 32'(SYNC_RESET));

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (DIRECTED_ROWS[i].phase != phase_now) begin
            req_tvalid <= 1'b0;
            wait_drained();
            phase_now = DIRECTED_ROWS[i].phase;
            case (phase_now)
               3'd1: begin
                  // Both counts drop to one while the packet is open.
                  program_register(REG_CHANNELS, 32'd1);
                  program_register(REG_SAMPLES, 32'd1);
                  program_register(REG_REVERSE, 32'd0);
                  program_register(REG_SYNC, 32'h1234);
               end
               3'd2: begin
                  program_register(REG_CHANNELS, 32'd0);
                  program_register(REG_SAMPLES, 32'd0);
                  program_register(REG_SYNC, 32'h0000);
                  program_register(REG_REVERSE, 32'd1);
               end
               3'd3: begin
                  program_register(REG_CHANNELS, 32'd15);
                  program_register(REG_SAMPLES, 32'd255);
                  program_register(REG_SYNC, 32'hFFFF);
               end
               default: begin
                  // The channel index is already past the new count.
                  program_register(REG_CHANNELS, 32'd2);
                  program_register(REG_SAMPLES, 32'd1);
               end
            endcase
         end
         send_reading(DIRECTED_ROWS[i].lo, DIRECTED_ROWS[i].hi);
         base  = pending_bytes.size() - run_length;
         known = DIRECTED_ROWS[i].known;
         for (int k = 0; k < int'(DIRECTED_ROWS[i].n_known); k++) begin
            pending_bytes[base + k].out_byte = known[39 - 8 * k -: 8];
         end
      end
      req_tvalid <= 1'b0;

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         program_register(REG_CHANNELS, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 15) : $urandom_range(1, 3));
         program_register(REG_SAMPLES, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 255) : $urandom_range(1, 4));
         program_register(REG_REVERSE, $urandom_range(0, 1));
         program_register(REG_SYNC, $urandom_range(0, 65535));
         idle_pct <= (p == 1) ? 0 : 20;
         if (p == 2) begin
            hold_request <= 1'b1;
         end
         repeat ($urandom_range(16, 28)) begin
            send_reading($urandom_range(0, 255), $urandom_range(0, 255));
         end
         req_tvalid <= 1'b0;
      end

      // A run of one-reading packets.
      wait_drained();
      idle_pct <= 20;
      program_register(REG_CHANNELS, 32'd1);
      program_register(REG_SAMPLES, 32'd1);
      program_register(REG_REVERSE, $urandom_range(0, 1));
      program_register(REG_SYNC, $urandom_range(0, 65535));
      count = 20;
      repeat (count) begin
         send_reading($urandom_range(0, 255), $urandom_range(0, 255));
      end
      req_tvalid <= 1'b0;

      while (pending_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
